// ===== rtl/dfcs_pkg.sv =====
`timescale 1ns / 1ps

package dfcs_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 8;
  localparam int SEL_W       = 3;
  localparam int POS_W       = 7;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int CFG_INDEX_W = 2;

  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd60;
  localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'd62;

  typedef enum logic [OP_W-1:0] {
    OP_RECEIVE = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_STORED   = 3'd1,
    ST_NO_SLOT  = 3'd2,
    ST_DISABLED = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_END_BYTE   = 2'd1,
    CFG_ENABLED    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] rx_byte;
    logic [SEL_W-1:0]  slot_select;
    logic [POS_W-1:0]  position;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEL_W-1:0]    slot_out;
    logic [BYTE_W-1:0]   data;
    logic [LEN_W-1:0]    length;
  } out_t;

  typedef struct packed {
    logic load_item;
    logic start_read;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
  } dp_status_t;

endpackage

// ===== rtl/dfcs_ram.sv =====
`timescale 1ns / 1ps

module dfcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1152,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dfcs_ctrl.sv =====
`timescale 1ns / 1ps

module dfcs_ctrl import dfcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  output logic       result_valid,
  input  logic       result_stall,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   result_valid_next;
  logic   out_free;

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_read) begin
          cmd.start_read = 1'b1;
          state_next     = S_READ;
        end else if (out_free) begin
          cmd.commit   = 1'b1;
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    result_valid_next = cmd.load_out || (result_valid && result_stall);
  end

endmodule

// ===== rtl/dfcs_datapath.sv =====
`timescale 1ns / 1ps

module dfcs_datapath import dfcs_pkg::*; #(
  parameter int SLOTS       = 8,
  parameter int FRAME_BYTES = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  input  in_t                    item,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             stat,
  output out_t                   result
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW    = $clog2(SLOTS + 1);
  localparam int OW    = $clog2(FRAME_BYTES);
  localparam int DEPTH = (SLOTS + 1) * (2 ** OW);
  localparam int AW    = PW + OW;

  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;
  logic              enabled;

  in_t               cur;
  logic [LEN_W-1:0]  capture_count;
  logic              capturing;
  logic              overflowed;
  logic [LEN_W-1:0]  lengths [SLOTS];
  logic [PW-1:0]     buf_map [SLOTS];
  logic [PW-1:0]     staging;

  logic [SW-1:0]     sel_idx;
  logic              sel_in_range;
  logic [LEN_W-1:0]  sel_len;
  logic              sel_ok;
  logic              any_free;
  logic [SW-1:0]     free_idx;
  logic [SW-1:0]     map_idx;
  logic [PW-1:0]     map_out;
  logic              is_start;
  logic              appending;
  logic              fits;
  logic [LEN_W-1:0]  count_after;
  logic              closes;
  logic              ovf_now;
  status_t           close_status;
  logic [LEN_W-1:0]  pos_ext;
  logic              read_hit;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  out_t              res;

  assign sel_idx      = SW'(cur.slot_select);
  assign sel_in_range = 32'(cur.slot_select) < SLOTS;
  assign sel_len      = sel_in_range ? lengths[sel_idx] : '0;
  assign sel_ok       = sel_in_range && (sel_len != '0);
  assign pos_ext      = LEN_W'(cur.position);
  assign read_hit     = sel_ok && (pos_ext < sel_len);

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (lengths[i] == '0) begin
        any_free = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign map_idx = (cur.operation == OP_READ) ? sel_idx : free_idx;
  assign map_out = buf_map[map_idx];

  assign is_start    = cur.rx_byte == start_byte;
  assign appending   = capturing && !is_start;
  assign fits        = capture_count < LEN_W'(FRAME_BYTES);
  assign count_after = fits ? capture_count + LEN_W'(1) : capture_count;
  assign closes      = appending && (cur.rx_byte == end_byte);
  assign ovf_now     = overflowed || !fits;

  always_comb begin
    if (ovf_now) begin
      close_status = ST_OVERFLOW;
    end else if (!enabled) begin
      close_status = ST_DISABLED;
    end else if (!any_free) begin
      close_status = ST_NO_SLOT;
    end else begin
      close_status = ST_STORED;
    end
  end

  assign ram_we    = cmd.commit && (cur.operation == OP_RECEIVE) &&
                     (is_start || (appending && fits));
  assign ram_waddr = {staging, is_start ? {OW{1'b0}} : capture_count[OW-1:0]};
  assign ram_re    = cmd.start_read;
  assign ram_raddr = {map_out, pos_ext[OW-1:0]};

  dfcs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    res = '0;
    case (cur.operation)
      OP_RECEIVE: begin
        if (closes) begin
          res.status = close_status;
          res.length = count_after;
          if (close_status == ST_STORED) begin
            res.slot_out = SEL_W'(free_idx);
          end
        end
      end
      OP_READ: begin
        res.slot_out = cur.slot_select;
        if (!sel_ok) begin
          res.status = ST_EMPTY;
        end else begin
          res.length = sel_len;
          res.data   = read_hit ? ram_rdata : '0;
        end
      end
      OP_RELEASE: begin
        res.slot_out = cur.slot_select;
        if (!sel_ok) begin
          res.status = ST_EMPTY;
        end else begin
          res.length = sel_len;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign stat.is_read = cur.operation == OP_READ;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur <= item;
    end
    if (cmd.load_out) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= START_BYTE_RESET;
      end_byte      <= END_BYTE_RESET;
      enabled       <= 1'b0;
      capture_count <= '0;
      capturing     <= 1'b0;
      overflowed    <= 1'b0;
      staging       <= PW'(SLOTS);
      for (int i = 0; i < SLOTS; i++) begin
        lengths[i] <= '0;
        buf_map[i] <= PW'(i);
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_BYTE: start_byte <= cfg_data;
          CFG_END_BYTE:   end_byte   <= cfg_data;
          CFG_ENABLED:    enabled    <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        case (cur.operation)
          OP_RECEIVE: begin
            if (is_start) begin
              capture_count <= LEN_W'(1);
              capturing     <= 1'b1;
              overflowed    <= 1'b0;
            end else if (capturing) begin
              capture_count <= count_after;
              if (closes) begin
                capturing  <= 1'b0;
                overflowed <= 1'b0;
                if (close_status == ST_STORED) begin
                  lengths[free_idx] <= count_after;
                  buf_map[free_idx] <= staging;
                  staging           <= map_out;
                end
              end else begin
                overflowed <= ovf_now;
              end
            end
          end
          OP_RELEASE: begin
            if (sel_ok) begin
              lengths[sel_idx] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/delimited_frame_capture_slots.sv =====
`timescale 1ns / 1ps

// Captures start/end delimited frames from a byte stream and files each closed frame into the
// lowest-numbered empty message slot (unless overflowed, disabled or with no slot free), with
// read and release operations for the consumer. One item is processed at a time: a receive or
// release is accepted, then executed; a read adds a state for the registered read of the frame
// memory. The result sits in an output register, so a new item is accepted while it waits, but
// that item completes only after the waiting result has been transferred. Frames are staged in
// a spare buffer of the frame memory; closing a frame swaps that buffer into the slot through a
// small map, so no copy is needed. The memory holds SLOTS + 1 buffers and needs no reset clear.
module delimited_frame_capture_slots import dfcs_pkg::*; #(
  parameter int SLOTS       = 8,
  parameter int FRAME_BYTES = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  in_t                    item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output out_t                   result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  dfcs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  dfcs_datapath #(
    .SLOTS       (SLOTS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while another is in flight");

  a_stored_has_delimiters: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_STORED) |-> result.length >= 8'd2)
    else $error("stored frame shorter than its two delimiters");

  a_empty_reports_nothing: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_EMPTY) |->
      (result.length == '0) && (result.data == '0))
    else $error("empty slot result carries data or length");

endmodule
